[rtl/core/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg: shared definitions for the partition fit allocator
// Field widths, command and status codes, register indexes and the scan
// control group broadcast along the cell chain.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // fixed field widths of the ports
  localparam int ACTION_W    = 1;
  localparam int INDEX_W     = 3;
  localparam int AMOUNT_W    = 16;
  localparam int STATUS_W    = 2;
  localparam int POLICY_W    = 2;
  localparam int COUNT_W     = 4;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  // defaults for the top level parameters
  localparam int NUM_BLOCKS_DEF = 8;
  localparam int SIZE_WIDTH_DEF = 16;

  // input actions
  localparam logic [ACTION_W-1:0] ACT_LOAD     = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_ALLOCATE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_LOADED    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REFUSED   = 2'd2;

  // placement policies; the spare code behaves as first fit
  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_POLICY      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b1;

  // register reset values
  localparam logic [POLICY_W-1:0] POLICY_RESET      = POLICY_FIRST;
  localparam logic [COUNT_W-1:0]  BLOCK_COUNT_RESET = 4'd3;

  // scan control seen by every cell
  typedef struct packed {
    logic [POLICY_W-1:0] policy;
    logic [COUNT_W-1:0]  limit;
  } scan_ctrl_t;

endpackage

[rtl/core/partition_fit_allocator.sv]
// ----------------------------------------------------------------------------
// partition_fit_allocator: first, best and worst fit partition allocator
// Keeps the free space of a row of partitions and places allocate requests
// by the configured policy, shrinking the chosen partition.
// ----------------------------------------------------------------------------
// Usage
//   An item is taken at a clock edge with start high and busy low. A load
//   item writes the partition at once; its result comes on the next cycle
//   and busy stays low, so loads may follow back to back.
//   An allocate item raises busy and sends a search token down a chain of
//   NUM_BLOCKS cells, one cell per cycle. The result strobe done rises
//   once the token has passed the launch register, every cell and the done
//   register; busy falls in the cycle done is high, so the next item can be
//   taken at the edge that ends it. The chain length sets the allocate
//   latency and rate. Each result sits on status, chosen_block, space_left
//   and last_result for exactly the one cycle that done is high; the receiver
//   cannot stall. Configuration is written through cfg_write, cfg_index and
//   cfg_data at an edge: index 0 policy, index 1 block count. The user must
//   write it only while the block is idle; the block does not enforce this.
//   Reset (rst, synchronous) clears every partition to zero free space, sets
//   first fit and a block count of three, and drops busy and done.
// ----------------------------------------------------------------------------
module partition_fit_allocator
  import pfa_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [ACTION_W-1:0]    action,
  input  logic [INDEX_W-1:0]     block_index,
  input  logic [AMOUNT_W-1:0]    amount,
  input  logic                   last_request,
  output logic                   done,
  output logic [STATUS_W-1:0]    status,
  output logic [INDEX_W-1:0]     chosen_block,
  output logic [AMOUNT_W-1:0]    space_left,
  output logic                   last_result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int XW    = ((IDX_W > INDEX_W) ? IDX_W : INDEX_W) + 1;
  localparam int CMP_W = ($clog2(NUM_BLOCKS + 1) > COUNT_W) ?
                         $clog2(NUM_BLOCKS + 1) : COUNT_W;

  logic [POLICY_W-1:0]   policy;
  logic [COUNT_W-1:0]    block_count;
  scan_ctrl_t            ctrl;
  logic [CMP_W-1:0]      count_wide;

  logic [SIZE_WIDTH-1:0] amt_m;
  logic [XW-1:0]         idx_x;
  logic                  idx_ok;
  logic                  accept;
  logic                  accept_load;
  logic                  accept_alloc;

  logic                  launch_valid;
  logic [SIZE_WIDTH-1:0] launch_amt;
  logic                  last_hold;

  wire                   tok_valid [NUM_BLOCKS+1];
  wire  [SIZE_WIDTH-1:0] tok_amt   [NUM_BLOCKS+1];
  wire                   tok_found [NUM_BLOCKS+1];
  wire  [IDX_W-1:0]      tok_pick  [NUM_BLOCKS+1];
  wire  [SIZE_WIDTH-1:0] tok_space [NUM_BLOCKS+1];

  logic                  fin_valid;
  logic                  grant;
  logic [SIZE_WIDTH-1:0] remain;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_index;
  logic [SIZE_WIDTH-1:0] wr_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POLICY_RESET;
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POLICY:      policy      <= cfg_data[POLICY_W-1:0];
        REG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  // scan limit clipped to the partitions that exist
  assign count_wide  = CMP_W'(block_count);
  assign ctrl.policy = policy;
  assign ctrl.limit  = (count_wide > CMP_W'(NUM_BLOCKS)) ?
                       COUNT_W'(NUM_BLOCKS) : block_count;

  // input transfer decode
  assign accept       = start && !busy;
  assign accept_load  = accept && (action == ACT_LOAD);
  assign accept_alloc = accept && (action == ACT_ALLOCATE);
  assign amt_m        = SIZE_WIDTH'(amount);
  assign idx_x        = XW'(block_index);
  assign idx_ok       = (idx_x < XW'(NUM_BLOCKS));

  // busy spans the search of one allocate item
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept_alloc) begin
      busy <= 1'b1;
    end else if (fin_valid) begin
      busy <= 1'b0;
    end
  end

  // token launch into the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      launch_valid <= 1'b0;
    end else begin
      launch_valid <= accept_alloc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      launch_amt <= amt_m;
      last_hold  <= last_request;
    end
  end

  assign tok_valid[0] = launch_valid;
  assign tok_amt[0]   = launch_amt;
  assign tok_found[0] = 1'b0;
  assign tok_pick[0]  = '0;
  assign tok_space[0] = '0;

  // chain of partition cells
  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
    pfa_cell #(
      .J          (g),
      .SIZE_WIDTH (SIZE_WIDTH),
      .IDX_W      (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .wr_en     (wr_en),
      .wr_index  (wr_index),
      .wr_data   (wr_data),
      .in_valid  (tok_valid[g]),
      .in_amt    (tok_amt[g]),
      .in_found  (tok_found[g]),
      .in_pick   (tok_pick[g]),
      .in_space  (tok_space[g]),
      .out_valid (tok_valid[g+1]),
      .out_amt   (tok_amt[g+1]),
      .out_found (tok_found[g+1]),
      .out_pick  (tok_pick[g+1]),
      .out_space (tok_space[g+1])
    );
  end

  // token leaving the tail of the chain
  assign fin_valid = tok_valid[NUM_BLOCKS];
  assign grant     = fin_valid && tok_found[NUM_BLOCKS];
  assign remain    = tok_space[NUM_BLOCKS] - tok_amt[NUM_BLOCKS];

  // shared write port: load, or write-back of a grant
  assign wr_en    = (accept_load && idx_ok) || grant;
  assign wr_index = grant ? tok_pick[NUM_BLOCKS] : IDX_W'(idx_x);
  assign wr_data  = grant ? remain : amt_m;

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept_load || fin_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept_load) begin
      status       <= STAT_LOADED;
      chosen_block <= block_index;
      space_left   <= idx_ok ? AMOUNT_W'(amt_m) : '0;
      last_result  <= last_request;
    end else if (fin_valid) begin
      status       <= grant ? STAT_ALLOCATED : STAT_REFUSED;
      chosen_block <= grant ? INDEX_W'(tok_pick[NUM_BLOCKS]) : '0;
      space_left   <= grant ? AMOUNT_W'(remain) : '0;
      last_result  <= last_hold;
    end
  end

`ifndef SYNTHESIS
  logic [NUM_BLOCKS:0] tok_vec;

  always_comb begin
    for (int k = 0; k <= NUM_BLOCKS; k++) begin
      tok_vec[k] = tok_valid[k];
    end
  end

  // exactly one token in flight while busy, none otherwise
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_vec) == (busy ? 1 : 0))
    else $error("token count does not match busy");

  // an allocate transfer starts a search
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    accept_alloc |=> busy && launch_valid)
    else $error("allocate transfer did not start a search");

  // a finished search gives one result and frees the block
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    fin_valid |=> done && !busy && (status != STAT_LOADED))
    else $error("finished search did not give an allocate result");

  // a load transfer is answered on the next cycle
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    accept_load |=> done && (status == STAT_LOADED))
    else $error("load transfer not answered");

  // a refused request reports no partition and no space
  a_refused: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_REFUSED)) |-> (chosen_block == '0) && (space_left == '0))
    else $error("refused result carries a partition");
`endif

endmodule

[rtl/core/pfa_cell.sv]
// ----------------------------------------------------------------------------
// pfa_cell: one partition of the allocator chain
// Holds the free space of one partition, compares it with the search token
// passing by and forwards the updated token to the next cell each cycle.
// ----------------------------------------------------------------------------
module pfa_cell
  import pfa_pkg::*;
#(
  parameter int J          = 0,
  parameter int SIZE_WIDTH = SIZE_WIDTH_DEF,
  parameter int IDX_W      = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scan_ctrl_t            ctrl,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_index,
  input  logic [SIZE_WIDTH-1:0] wr_data,
  input  logic                  in_valid,
  input  logic [SIZE_WIDTH-1:0] in_amt,
  input  logic                  in_found,
  input  logic [IDX_W-1:0]      in_pick,
  input  logic [SIZE_WIDTH-1:0] in_space,
  output logic                  out_valid,
  output logic [SIZE_WIDTH-1:0] out_amt,
  output logic                  out_found,
  output logic [IDX_W-1:0]      out_pick,
  output logic [SIZE_WIDTH-1:0] out_space
);

  // position of this cell, in the widths it is compared at
  localparam bit                 IN_RANGE = (J < (1 << COUNT_W));
  localparam logic [COUNT_W-1:0] J_CNT    = COUNT_W'(IN_RANGE ? J : 0);
  localparam logic [IDX_W-1:0]   J_IDX    = IDX_W'(J);

  logic [SIZE_WIDTH-1:0] space;
  logic                  active;
  logic                  fits;
  logic                  better;
  logic                  take;

  // partition inside the scanned range and big enough
  assign active = IN_RANGE && (J_CNT < ctrl.limit);
  assign fits   = (space != '0) && (space >= in_amt);

  // does this partition beat the candidate carried so far
  always_comb begin
    case (ctrl.policy)
      POLICY_BEST:  better = (space < in_space);
      POLICY_WORST: better = (space > in_space);
      default:      better = 1'b0;
    endcase
  end

  assign take = in_valid && active && fits && (!in_found || better);

  // free space store, written by loads and by the grant write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      space <= '0;
    end else if (wr_en && (wr_index == J_IDX)) begin
      space <= wr_data;
    end
  end

  // token valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    out_amt   <= in_amt;
    out_found <= in_found || take;
    out_pick  <= take ? J_IDX : in_pick;
    out_space <= take ? space : in_space;
  end

endmodule

[dv/tb_partition_fit_allocator.sv]
// ----------------------------------------------------------------------------
// tb_partition_fit_allocator: self-checking bench for the partition allocator
// Loads partitions and issues allocate requests under every placement policy
// and a spread of block counts. A ledger of free space predicts each result,
// and the strobed outputs are checked field by field in order of transfer.
// ----------------------------------------------------------------------------
module tb_partition_fit_allocator;
  import pfa_pkg::*;

  localparam int NBLK        = NUM_BLOCKS_DEF;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 94;
  localparam int MAX_REPORTS = 10;

  // spare policy code, behaves as first fit
  localparam logic [POLICY_W-1:0] POLICY_SPARE = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  blk;
    logic [AMOUNT_W-1:0] left;
    logic                last;
  } alloc_result_t;

  // free-space ledger and queue of awaited results
  class fit_ledger;
    logic [AMOUNT_W-1:0] space [NBLK];
    logic [POLICY_W-1:0] policy;
    logic [COUNT_W-1:0]  block_count;
    alloc_result_t       awaited [$];
    int                  mismatches;

    function new();
      foreach (space[i]) space[i] = '0;
      policy      = POLICY_RESET;
      block_count = BLOCK_COUNT_RESET;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_POLICY) begin
        policy = val[POLICY_W-1:0];
      end else if (idx == REG_BLOCK_COUNT) begin
        block_count = val[COUNT_W-1:0];
      end
    endfunction

    // place a request by the current policy and shrink the chosen partition
    function alloc_result_t place_request(logic [AMOUNT_W-1:0] req, logic last);
      alloc_result_t r;
      int            lim;
      int            pick;
      bit            found;
      bit            first_only;
      lim        = (block_count > NBLK) ? NBLK : int'(block_count);
      first_only = (policy == POLICY_FIRST) || (policy == POLICY_SPARE);
      found      = 1'b0;
      pick       = 0;
      for (int j = 0; j < lim; j++) begin
        // an empty partition never fits, not even a zero-size request
        if (space[j] != '0 && space[j] >= req && !(found && first_only)) begin
          if (!found) begin
            found = 1'b1;
            pick  = j;
          end else if (policy == POLICY_BEST && space[j] < space[pick]) begin
            pick = j;
          end else if (policy == POLICY_WORST && space[j] > space[pick]) begin
            pick = j;
          end
        end
      end
      r.last = last;
      if (!found) begin
        r.status = STAT_REFUSED;
        r.blk    = '0;
        r.left   = '0;
      end else begin
        space[pick] = space[pick] - req;
        r.status    = STAT_ALLOCATED;
        r.blk       = pick[INDEX_W-1:0];
        r.left      = space[pick];
      end
      return r;
    endfunction

    // accepted item: work out its result
    function void note_item(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx,
                            logic [AMOUNT_W-1:0] amt, logic last);
      alloc_result_t r;
      if (act == ACT_LOAD) begin
        space[idx] = amt;
        r.status   = STAT_LOADED;
        r.blk      = idx;
        r.left     = amt;
        r.last     = last;
      end else begin
        r = place_request(amt, last);
      end
      awaited.push_back(r);
    endfunction

    // strobed result: compare with the oldest awaited one
    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result status %0d block %0d left %0d last %0d",
                   $time, got.status, got.blk, got.left, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.blk !== want.blk ||
          got.left !== want.left || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: expected status %0d block %0d left %0d last %0d, got %0d %0d %0d %0d",
                   $time, want.status, want.blk, want.left, want.last,
                   got.status, got.blk, got.left, got.last);
      end
    endfunction
  endclass

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   start        = 1'b0;
  logic                   busy;
  logic [ACTION_W-1:0]    action       = ACT_LOAD;
  logic [INDEX_W-1:0]     block_index  = '0;
  logic [AMOUNT_W-1:0]    amount       = '0;
  logic                   last_request = 1'b0;
  logic                   done;
  logic [STATUS_W-1:0]    status;
  logic [INDEX_W-1:0]     chosen_block;
  logic [AMOUNT_W-1:0]    space_left;
  logic                   last_result;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  fit_ledger ledger;
  int        gap_pct = 0;

  partition_fit_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .block_index  (block_index),
    .amount       (amount),
    .last_request (last_request),
    .done         (done),
    .status       (status),
    .chosen_block (chosen_block),
    .space_left   (space_left),
    .last_result  (last_result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // result check at every strobe
  always @(posedge clk) begin
    if (!rst && done)
      ledger.check_result(alloc_result_t'({status, chosen_block, space_left, last_result}));
  end

  // one item transfer, entered and left at a falling edge
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                           input logic [AMOUNT_W-1:0] amt, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      start        = 1'b0;
      action       = ACTION_W'($urandom_range(1));
      block_index  = INDEX_W'($urandom_range(NBLK - 1));
      amount       = AMOUNT_W'($urandom);
      last_request = 1'($urandom_range(1));
      @(negedge clk);
    end
    start        = 1'b1;
    action       = act;
    block_index  = idx;
    amount       = amt;
    last_request = last;
    @(posedge clk);
    while (busy) @(posedge clk);
    ledger.note_item(act, idx, amt, last);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    ledger.set_reg(idx, val);
  endtask

  // wait for every awaited result, then for the chain to drain
  task automatic settle();
    while (ledger.awaited.size() != 0) @(negedge clk);
    repeat (NBLK + 4) @(negedge clk);
  endtask

  // random item: mostly allocates, some sized against current free space
  task automatic random_item();
    logic [AMOUNT_W-1:0] amt;
    int                  peer;
    peer = $urandom_range(NBLK - 1);
    if ($urandom_range(99) < 35) begin
      case ($urandom_range(7))
        0:       amt = 16'd128;
        1:       amt = 16'd256;
        2:       amt = 16'd150;
        3:       amt = '0;
        4:       amt = '1;
        5:       amt = ledger.space[peer];
        6:       amt = AMOUNT_W'($urandom);
        default: amt = AMOUNT_W'($urandom_range(1000));
      endcase
      send_item(ACT_LOAD, INDEX_W'($urandom_range(NBLK - 1)), amt,
                1'($urandom_range(1)));
    end else begin
      case ($urandom_range(6))
        0:       amt = '0;
        1:       amt = ledger.space[peer];
        2:       amt = ledger.space[peer] + 1'b1;
        3:       amt = AMOUNT_W'($urandom_range(64));
        4:       amt = AMOUNT_W'($urandom_range(300));
        5:       amt = AMOUNT_W'(ledger.space[peer] - $urandom_range(8));
        default: amt = AMOUNT_W'($urandom);
      endcase
      send_item(ACT_ALLOCATE, INDEX_W'($urandom_range(NBLK - 1)), amt,
                1'($urandom_range(1)));
    end
  endtask

  logic [POLICY_W-1:0] phase_policy [PHASES] = '{
    POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_SPARE, POLICY_BEST, POLICY_WORST,
    POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_FIRST, POLICY_BEST, POLICY_WORST
  };
  logic [COUNT_W-1:0]  phase_count  [PHASES] = '{
    4'd8, 4'd8, 4'd8, 4'd6, 4'd1, 4'd15, 4'd0, 4'd9, 4'd4, 4'd2, 4'd5, 4'd8
  };

  initial begin
    ledger = new();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // reset settings: first fit over three partitions
    send_item(ACT_LOAD, 3'd0, 16'd128, 1'b0);
    send_item(ACT_LOAD, 3'd1, 16'd256, 1'b0);
    send_item(ACT_LOAD, 3'd2, 16'd150, 1'b0);
    send_item(ACT_ALLOCATE, 3'd0, 16'd100, 1'b0);
    send_item(ACT_ALLOCATE, 3'd7, 16'd0, 1'b0);
    send_item(ACT_ALLOCATE, 3'd5, 16'hffff, 1'b1);
    send_item(ACT_LOAD, 3'd5, 16'hffff, 1'b0);
    send_item(ACT_ALLOCATE, 3'd0, 16'd200, 1'b1);
    send_item(ACT_LOAD, 3'd7, 16'h5a5a, 1'b1);

    // best fit over all partitions, with a tie and an empty partition
    settle();
    write_reg(REG_POLICY, POLICY_BEST);
    write_reg(REG_BLOCK_COUNT, 4'd8);
    send_item(ACT_LOAD, 3'd3, 16'd150, 1'b0);
    send_item(ACT_LOAD, 3'd4, 16'd0, 1'b0);
    send_item(ACT_ALLOCATE, 3'd0, 16'd100, 1'b0);
    send_item(ACT_ALLOCATE, 3'd0, 16'd0, 1'b1);

    // worst fit, exact fit leaving an empty partition
    settle();
    write_reg(REG_POLICY, POLICY_WORST);
    send_item(ACT_ALLOCATE, 3'd2, 16'hffff, 1'b0);
    send_item(ACT_ALLOCATE, 3'd2, 16'd1, 1'b0);
    send_item(ACT_ALLOCATE, 3'd2, 16'd0, 1'b1);

    // spare policy code
    settle();
    write_reg(REG_POLICY, POLICY_SPARE);
    send_item(ACT_ALLOCATE, 3'd1, 16'd10, 1'b0);

    // block count of zero refuses everything, above the maximum scans all
    settle();
    write_reg(REG_BLOCK_COUNT, 4'd0);
    send_item(ACT_ALLOCATE, 3'd0, 16'd0, 1'b0);
    settle();
    write_reg(REG_BLOCK_COUNT, 4'd15);
    write_reg(REG_POLICY, POLICY_BEST);
    send_item(ACT_ALLOCATE, 3'd0, 16'd1, 1'b1);

    // random phases over a spread of settings
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_POLICY, phase_policy[p]);
      write_reg(REG_BLOCK_COUNT, phase_count[p]);
      gap_pct = (p == 4) ? 0 : 36;
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    settle();
    if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
      $display("** partition_fit_allocator: PASSED **");
    end else begin
      $display("** partition_fit_allocator: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("** partition_fit_allocator: FAILED **");
    $finish;
  end

endmodule
